// ===== rtl/ifsc_pkg.sv =====
// ----------------------------------------------------------------------------
// ifsc_pkg
// Types, constants and codes shared by the feeder stall controller.
// ----------------------------------------------------------------------------
package ifsc_pkg;

    // geometry of the feeder drive
    localparam int ENCODER_RES     = 8192;
    localparam int TURNS_PER_ROUND = 36;
    localparam int STALL_CEIL      = 1000;
    localparam int STALL_FLOOR     = 0;

    localparam int ROUND_LEN  = ENCODER_RES * TURNS_PER_ROUND;
    localparam int HALF_ROUND = ROUND_LEN / 2;
    localparam int HALF_RES   = ENCODER_RES / 2;

    localparam int ANGLE_W = $clog2(ENCODER_RES);
    localparam int POS_W   = $clog2(ROUND_LEN);
    localparam int TURN_W  = $clog2(TURNS_PER_ROUND + 1);
    localparam int STALL_W = 16;

    // field and register widths
    localparam int SW_W        = 2;
    localparam int STEP_W      = 19;
    localparam int BAND_W      = 13;
    localparam int LEVEL_W     = 16;
    localparam int REV_W       = 16;
    localparam int TOL_W       = 18;
    localparam int FEED_W      = 14;
    localparam int SPEED_W     = 15;
    localparam int MODE_W      = 3;
    localparam int CFG_DATA_W  = 19;
    localparam int CFG_INDEX_W = 3;

    typedef enum logic [MODE_W-1:0] {
        MODE_STOP   = 3'd0,
        MODE_READY  = 3'd1,
        MODE_SHOOT  = 3'd2,
        MODE_DONE   = 3'd3,
        MODE_LOCKED = 3'd4
    } mode_t;

    typedef enum logic [SW_W-1:0] {
        SW_UP   = 2'd0,
        SW_MID  = 2'd1,
        SW_DOWN = 2'd2
    } switch_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_STEP_COUNTS      = 3'd0,
        REG_STALL_BAND       = 3'd1,
        REG_STALL_SHORT      = 3'd2,
        REG_STALL_LONG       = 3'd3,
        REG_REVERSE_TICKS    = 3'd4,
        REG_ARRIVE_TOLERANCE = 3'd5,
        REG_FEED_SPEED       = 3'd6,
        REG_FORWARD_DIR      = 3'd7
    } cfg_index_t;

    typedef struct packed {
        logic [STEP_W-1:0]         step_counts;
        logic [BAND_W-1:0]         stall_band;
        logic signed [LEVEL_W-1:0] stall_short;
        logic signed [LEVEL_W-1:0] stall_long;
        logic [REV_W-1:0]          reverse_ticks;
        logic [TOL_W-1:0]          arrive_tolerance;
        logic [FEED_W-1:0]         feed_speed;
        logic                      forward_dir;
    } cfg_t;

    typedef struct packed {
        mode_t                     mode;
        logic [POS_W-1:0]          target;
        logic [TURN_W-1:0]         turn;
        logic [ANGLE_W-1:0]        last_angle;
        logic signed [STALL_W-1:0] stall;
        logic [REV_W-1:0]          reverse;
        logic                      driven;   // last speed was nonzero
    } state_t;

    localparam logic [STEP_W-1:0]         STEP_RST  = STEP_W'(36864);
    localparam logic [BAND_W-1:0]         BAND_RST  = BAND_W'(50);
    localparam logic signed [LEVEL_W-1:0] SHORT_RST = LEVEL_W'(50);
    localparam logic signed [LEVEL_W-1:0] LONG_RST  = LEVEL_W'(200);
    localparam logic [REV_W-1:0]          REV_RST   = REV_W'(100);
    localparam logic [TOL_W-1:0]          TOL_RST   = TOL_W'(500);
    localparam logic [FEED_W-1:0]         FEED_RST  = FEED_W'(2000);

endpackage

// ===== rtl/ifsc_cfg.sv =====
// ----------------------------------------------------------------------------
// ifsc_cfg
// Configuration register file, written through a plain indexed write port.
// ----------------------------------------------------------------------------
module ifsc_cfg
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [ifsc_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [ifsc_pkg::CFG_DATA_W-1:0]   cfg_data,
    output ifsc_pkg::cfg_t                    cfg
);

    ifsc_pkg::cfg_t cfg_reg;
    ifsc_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            case (ifsc_pkg::cfg_index_t'(cfg_index))
                ifsc_pkg::REG_STEP_COUNTS:
                    cfg_next.step_counts = cfg_data[ifsc_pkg::STEP_W-1:0];
                ifsc_pkg::REG_STALL_BAND:
                    cfg_next.stall_band = cfg_data[ifsc_pkg::BAND_W-1:0];
                ifsc_pkg::REG_STALL_SHORT:
                    cfg_next.stall_short = cfg_data[ifsc_pkg::LEVEL_W-1:0];
                ifsc_pkg::REG_STALL_LONG:
                    cfg_next.stall_long = cfg_data[ifsc_pkg::LEVEL_W-1:0];
                ifsc_pkg::REG_REVERSE_TICKS:
                    cfg_next.reverse_ticks = cfg_data[ifsc_pkg::REV_W-1:0];
                ifsc_pkg::REG_ARRIVE_TOLERANCE:
                    cfg_next.arrive_tolerance = cfg_data[ifsc_pkg::TOL_W-1:0];
                ifsc_pkg::REG_FEED_SPEED:
                    cfg_next.feed_speed = cfg_data[ifsc_pkg::FEED_W-1:0];
                ifsc_pkg::REG_FORWARD_DIR:
                    cfg_next.forward_dir = cfg_data[0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.step_counts      <= ifsc_pkg::STEP_RST;
            cfg_reg.stall_band       <= ifsc_pkg::BAND_RST;
            cfg_reg.stall_short      <= ifsc_pkg::SHORT_RST;
            cfg_reg.stall_long       <= ifsc_pkg::LONG_RST;
            cfg_reg.reverse_ticks    <= ifsc_pkg::REV_RST;
            cfg_reg.arrive_tolerance <= ifsc_pkg::TOL_RST;
            cfg_reg.feed_speed       <= ifsc_pkg::FEED_RST;
            cfg_reg.forward_dir      <= 1'b1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/ifsc_step.sv =====
// ----------------------------------------------------------------------------
// ifsc_step
// One control tick: switch handling, shot arming, stall check, position
// tracking and speed selection, all combinational.
// ----------------------------------------------------------------------------
module ifsc_step
(
    input  ifsc_pkg::cfg_t                       cfg,
    input  ifsc_pkg::state_t                     st,
    input  logic [ifsc_pkg::SW_W-1:0]            sw,
    input  logic                                 fire,
    input  logic [ifsc_pkg::ANGLE_W-1:0]         ecd,
    output ifsc_pkg::state_t                     st_next,
    output ifsc_pkg::mode_t                      mode_out,
    output logic signed [ifsc_pkg::SPEED_W-1:0]  speed_out
);

    localparam int PW = ifsc_pkg::POS_W;
    localparam int AW = ifsc_pkg::ANGLE_W;
    localparam int TW = ifsc_pkg::TURN_W;
    localparam int SW = ifsc_pkg::STALL_W;
    localparam int EW = ifsc_pkg::POS_W + 2;

    localparam logic [PW:0]           ROUND_X  = (PW+1)'(ifsc_pkg::ROUND_LEN);
    localparam logic signed [EW-1:0]  ROUND_E  = EW'(ifsc_pkg::ROUND_LEN);
    localparam logic signed [EW-1:0]  HALF_E   = EW'(ifsc_pkg::HALF_ROUND);
    localparam logic signed [AW:0]    HALF_A   = (AW+1)'(ifsc_pkg::HALF_RES);
    localparam logic signed [SW:0]    CEIL_S   = (SW+1)'(ifsc_pkg::STALL_CEIL);
    localparam logic signed [SW:0]    FLOOR_S  = (SW+1)'(ifsc_pkg::STALL_FLOOR);
    localparam logic signed [TW:0]    TURNS_S  = (TW+1)'(ifsc_pkg::TURNS_PER_ROUND);
    localparam logic signed [TW:0]    TOP_TURN = (TW+1)'(ifsc_pkg::TURNS_PER_ROUND - 1);

    ifsc_pkg::mode_t           m;
    logic [PW:0]               step_x;
    logic [PW-1:0]             step_w;
    logic [PW:0]               sum_up;
    logic [PW:0]               sum_dn;
    logic [PW-1:0]             tgt_up;
    logic [PW-1:0]             tgt_dn;
    logic signed [AW:0]        d;
    logic signed [AW:0]        band_s;
    logic                      still;
    logic signed [SW:0]        sc;
    logic signed [SW:0]        short_s;
    logic signed [SW:0]        long_s;
    logic signed [TW:0]        tc;
    logic [PW-1:0]             pos;
    logic signed [EW-1:0]      err;
    logic signed [SW-1:0]      stall_v;
    logic [ifsc_pkg::REV_W-1:0] rc;
    logic signed [ifsc_pkg::SPEED_W-1:0] fwd_speed;

    // step reduced by one round at most (register is below two rounds)
    assign step_x = (PW+1)'(cfg.step_counts);
    assign step_w = (step_x >= ROUND_X) ? PW'(step_x - ROUND_X) : PW'(step_x);
    assign sum_up = {1'b0, st.target} + {1'b0, step_w};
    assign sum_dn = {1'b0, st.target} - {1'b0, step_w};
    assign tgt_up = (sum_up >= ROUND_X) ? PW'(sum_up - ROUND_X) : PW'(sum_up);
    assign tgt_dn = sum_dn[PW] ? PW'(sum_dn + ROUND_X) : PW'(sum_dn);

    assign d       = $signed({1'b0, ecd}) - $signed({1'b0, st.last_angle});
    assign band_s  = $signed({1'b0, cfg.stall_band});
    assign still   = (d < band_s) && (d > -band_s);
    assign short_s = {cfg.stall_short[ifsc_pkg::LEVEL_W-1], cfg.stall_short};
    assign long_s  = {cfg.stall_long[ifsc_pkg::LEVEL_W-1], cfg.stall_long};

    assign fwd_speed = $signed({1'b0, cfg.feed_speed});

    always_comb
    begin
        st_next = st;
        m       = st.mode;
        sc      = {st.stall[SW-1], st.stall};
        rc      = st.reverse;
        tc      = $signed({1'b0, st.turn});
        pos     = '0;
        err     = '0;
        stall_v = st.stall;

        case (ifsc_pkg::switch_t'(sw))
            ifsc_pkg::SW_UP:
            begin
                if (m == ifsc_pkg::MODE_STOP || m == ifsc_pkg::MODE_DONE)
                    m = ifsc_pkg::MODE_READY;
            end
            ifsc_pkg::SW_MID:
                m = ifsc_pkg::MODE_STOP;
            default:
                m = m;
        endcase

        if (m == ifsc_pkg::MODE_READY)
        begin
            st_next.target = cfg.forward_dir ? tgt_up : tgt_dn;
            m = ifsc_pkg::MODE_SHOOT;
        end

        if (st.driven)
        begin
            sc = still ? sc + (SW+1)'(1) : sc - (SW+1)'(1);
            if (m == ifsc_pkg::MODE_LOCKED && rc != '1)
                rc = rc + ifsc_pkg::REV_W'(1);
            if (sc > CEIL_S)
                sc = CEIL_S;
            else if (sc < FLOOR_S)
                sc = FLOOR_S;
            stall_v = sc[SW-1:0];
            if (sc >= short_s)
                m = ifsc_pkg::MODE_LOCKED;
            else if (sc >= long_s)
                m = ifsc_pkg::MODE_STOP;
            if (m == ifsc_pkg::MODE_LOCKED && rc > cfg.reverse_ticks)
            begin
                m  = ifsc_pkg::MODE_SHOOT;
                rc = '0;
            end
        end
        st_next.stall   = stall_v;
        st_next.reverse = rc;

        if (m == ifsc_pkg::MODE_SHOOT)
        begin
            // wrap of the single-turn reading moves the turn count
            if (d >= HALF_A)
                tc = tc - (TW+1)'(1);
            else if (d <= -HALF_A)
                tc = tc + (TW+1)'(1);
            if (tc >= TURNS_S)
                tc = '0;
            else if (tc < 0)
                tc = TOP_TURN;
            st_next.turn       = tc[TW-1:0];
            st_next.last_angle = ecd;
            pos = PW'(tc[TW-1:0]) * PW'(ifsc_pkg::ENCODER_RES) + PW'(ecd);
            if (cfg.forward_dir)
                err = $signed(EW'(pos)) - $signed(EW'(st_next.target));
            else
                err = $signed(EW'(st_next.target)) - $signed(EW'(pos));
            if (err >= HALF_E)
                err = err - ROUND_E;
            if (err > $signed(EW'(cfg.arrive_tolerance)))
                m = fire ? ifsc_pkg::MODE_READY : ifsc_pkg::MODE_DONE;
        end

        case (m)
            ifsc_pkg::MODE_SHOOT, ifsc_pkg::MODE_READY:
                speed_out = cfg.forward_dir ? fwd_speed : -fwd_speed;
            ifsc_pkg::MODE_LOCKED:
                speed_out = cfg.forward_dir ? -fwd_speed : fwd_speed;
            default:
                speed_out = '0;
        endcase

        st_next.mode   = m;
        st_next.driven = (speed_out != '0);
        mode_out       = m;
    end

endmodule

// ===== rtl/indexed_feeder_stall_controller.sv =====
// ----------------------------------------------------------------------------
// indexed_feeder_stall_controller
// Per-tick feeder controller: mode, shot target tracking and stall reversal.
// ----------------------------------------------------------------------------
// One request in gives one result out. A request is captured in an input
// register and its result is loaded into the output register when that
// register is free or being emptied, which raises out_valid. The tick logic
// and its state registers update together with the output register, which
// sets the throughput at one request per clock for as long as the output
// side keeps taking results. Configuration writes take effect on the next
// edge; the user must make them while idle, the block does not enforce this.
module indexed_feeder_stall_controller
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [ifsc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [ifsc_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [ifsc_pkg::SW_W-1:0]           switch_pos,
    input  logic                                fire_button,
    input  logic [ifsc_pkg::ANGLE_W-1:0]        encoder_angle,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [ifsc_pkg::MODE_W-1:0]         mode,
    output logic signed [ifsc_pkg::SPEED_W-1:0] speed_target
);

    ifsc_pkg::cfg_t                       cfg;
    ifsc_pkg::state_t                     state_reg;
    ifsc_pkg::state_t                     state_next;
    ifsc_pkg::mode_t                      mode_calc;
    logic signed [ifsc_pkg::SPEED_W-1:0]  speed_calc;

    logic                                 s1_valid_reg;
    logic [ifsc_pkg::SW_W-1:0]            s1_sw_reg;
    logic                                 s1_fire_reg;
    logic [ifsc_pkg::ANGLE_W-1:0]         s1_angle_reg;
    logic                                 out_valid_reg;
    logic [ifsc_pkg::MODE_W-1:0]          mode_reg;
    logic signed [ifsc_pkg::SPEED_W-1:0]  speed_reg;

    logic                                 advance;
    logic                                 fire_tick;

    ifsc_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ifsc_step u_step
    (
        .cfg       (cfg),
        .st        (state_reg),
        .sw        (s1_sw_reg),
        .fire      (s1_fire_reg),
        .ecd       (s1_angle_reg),
        .st_next   (state_next),
        .mode_out  (mode_calc),
        .speed_out (speed_calc)
    );

    // output register free or being emptied this cycle
    assign advance   = !out_valid_reg || !out_stall;
    assign fire_tick = s1_valid_reg && advance;
    assign in_stall  = s1_valid_reg && !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            s1_sw_reg    <= switch_pos;
            s1_fire_reg  <= fire_button;
            s1_angle_reg <= encoder_angle;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.mode       <= ifsc_pkg::MODE_STOP;
            state_reg.target     <= '0;
            state_reg.turn       <= ifsc_pkg::TURN_W'(1);
            state_reg.last_angle <= '0;
            state_reg.stall      <= '0;
            state_reg.reverse    <= '0;
            state_reg.driven     <= 1'b0;
            out_valid_reg        <= 1'b0;
        end
        else
        begin
            if (fire_tick)
                state_reg <= state_next;
            if (advance)
                out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire_tick)
        begin
            mode_reg  <= mode_calc;
            speed_reg <= speed_calc;
        end
    end

    assign out_valid    = out_valid_reg;
    assign mode         = mode_reg;
    assign speed_target = speed_reg;

    // result of a stop or done tick never drives the motor
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (mode == ifsc_pkg::MODE_STOP || mode == ifsc_pkg::MODE_DONE)
        |-> speed_target == '0)
        else $error("motor driven in stop or done mode");

    // driven flag must track the last result handed out
    assert property (@(posedge clk) disable iff (!rst_n)
        fire_tick |=> state_reg.driven == (speed_target != '0))
        else $error("driven flag disagrees with last speed");

    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.stall >= ifsc_pkg::STALL_W'(ifsc_pkg::STALL_FLOOR)
        && state_reg.stall <= ifsc_pkg::STALL_W'(ifsc_pkg::STALL_CEIL))
        else $error("stall counter out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        (ifsc_pkg::POS_W + 1)'(state_reg.target)
        < (ifsc_pkg::POS_W + 1)'(ifsc_pkg::ROUND_LEN))
        else $error("target beyond one round");

    assert property (@(posedge clk) disable iff (!rst_n)
        fire_tick |=> out_valid && mode == $past(mode_calc))
        else $error("request lost between stages");

endmodule

// ===== dv/tb_indexed_feeder_stall_controller.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_indexed_feeder_stall_controller
// Self-checking bench for the feeder stall controller. A scoreboard keeps
// its own copy of the tick logic. Each accepted request is run through that
// copy, and each result the block returns is compared field by field with
// the oldest prediction. The stimulus is a crude motor model that moves the
// encoder the way the speed setpoint asks. It has stuck stretches, encoder
// glitches and random switch and fire activity, run under several register
// settings and handshake idling profiles.
// ----------------------------------------------------------------------------
module tb_indexed_feeder_stall_controller;

    import ifsc_pkg::*;

    localparam int                NUM_PHASES   = 7;
    localparam int                NUM_REGS     = 8;
    localparam int                DRAIN_CYCLES = 8;
    localparam int                HOLD_AT      = 1650;
    localparam int                HOLD_CYCLES  = 300;
    localparam int                REV_SAT      = 65535;
    localparam logic [SW_W-1:0]   SW_SPARE     = 2'd3;   // unused code, acts as down

    typedef struct packed {
        mode_t                     mode;
        logic signed [SPEED_W-1:0] speed;
    } tick_result_t;

    class feeder_scoreboard;
        cfg_t         regs;
        mode_t        cur_mode;
        int           target_pos;
        int           turns;
        int           last_ang;
        int           stall_cnt;
        int           rev_cnt;
        int           last_speed;
        tick_result_t due[$];
        int           errors;

        function new();
            regs.step_counts      = STEP_RST;
            regs.stall_band       = BAND_RST;
            regs.stall_short      = SHORT_RST;
            regs.stall_long       = LONG_RST;
            regs.reverse_ticks    = REV_RST;
            regs.arrive_tolerance = TOL_RST;
            regs.feed_speed       = FEED_RST;
            regs.forward_dir      = 1'b1;
            cur_mode   = MODE_STOP;
            target_pos = 0;
            turns      = 1;
            last_ang   = 0;
            stall_cnt  = 0;
            rev_cnt    = 0;
            last_speed = 0;
            errors     = 0;
        endfunction

        task log_mismatch(string msg);
            $display("mismatch at %0t: %s", $time, msg);
            errors++;
        endtask

        // one control tick, in the order switch, arm, stall, position, speed
        function void note_request(logic [SW_W-1:0] sw, logic fire,
                                   logic [ANGLE_W-1:0] ang);
            int           stp;
            int           t;
            int           d;
            int           band;
            int           pos;
            int           err;
            int           feed;
            int           spd;
            tick_result_t r;
            if (sw == SW_UP)
            begin
                if (cur_mode == MODE_STOP || cur_mode == MODE_DONE)
                    cur_mode = MODE_READY;
            end
            else if (sw == SW_MID)
                cur_mode = MODE_STOP;

            if (cur_mode == MODE_READY)
            begin
                stp = int'(regs.step_counts) % ROUND_LEN;
                if (regs.forward_dir)
                begin
                    t = target_pos + stp;
                    if (t >= ROUND_LEN)
                        t -= ROUND_LEN;
                end
                else
                begin
                    t = target_pos - stp;
                    if (t < 0)
                        t += ROUND_LEN;
                end
                target_pos = t;
                cur_mode   = MODE_SHOOT;
            end

            if (last_speed != 0)
            begin
                d    = int'(ang) - last_ang;
                band = int'(regs.stall_band);
                if (d < band && d > -band)
                    stall_cnt++;
                else
                    stall_cnt--;
                if (cur_mode == MODE_LOCKED && rev_cnt < REV_SAT)
                    rev_cnt++;
                if (stall_cnt > STALL_CEIL)
                    stall_cnt = STALL_CEIL;
                else if (stall_cnt < STALL_FLOOR)
                    stall_cnt = STALL_FLOOR;
                if (stall_cnt >= int'($signed(regs.stall_short)))
                    cur_mode = MODE_LOCKED;
                else if (stall_cnt >= int'($signed(regs.stall_long)))
                    cur_mode = MODE_STOP;
                if (cur_mode == MODE_LOCKED && rev_cnt > int'(regs.reverse_ticks))
                begin
                    cur_mode = MODE_SHOOT;
                    rev_cnt  = 0;
                end
            end

            if (cur_mode == MODE_SHOOT)
            begin
                d = int'(ang) - last_ang;
                if (d >= HALF_RES)
                    turns--;
                else if (d <= -HALF_RES)
                    turns++;
                last_ang = int'(ang);
                if (turns >= TURNS_PER_ROUND)
                    turns = 0;
                else if (turns < 0)
                    turns = TURNS_PER_ROUND - 1;
                pos = turns * ENCODER_RES + int'(ang);
                if (regs.forward_dir)
                    err = pos - target_pos;
                else
                    err = target_pos - pos;
                // error only wraps downward
                if (err >= HALF_ROUND)
                    err -= ROUND_LEN;
                if (err > int'(regs.arrive_tolerance))
                begin
                    if (fire)
                        cur_mode = MODE_READY;
                    else
                        cur_mode = MODE_DONE;
                end
            end

            feed = int'(regs.feed_speed);
            if (cur_mode == MODE_SHOOT || cur_mode == MODE_READY)
                spd = regs.forward_dir ? feed : -feed;
            else if (cur_mode == MODE_LOCKED)
                spd = regs.forward_dir ? -feed : feed;
            else
                spd = 0;
            last_speed = spd;

            r.mode  = cur_mode;
            r.speed = SPEED_W'(spd);
            due.push_back(r);
        endfunction

        task check_result(logic [MODE_W-1:0] m, logic signed [SPEED_W-1:0] s);
            tick_result_t e;
            if (due.size() == 0)
            begin
                log_mismatch($sformatf("unexpected result mode %0d speed %0d", m, s));
                return;
            end
            e = due.pop_front();
            if (m !== e.mode)
                log_mismatch($sformatf("mode %0d, predicted %0d", m, e.mode));
            if (s !== e.speed)
                log_mismatch($sformatf("speed %0d, predicted %0d", s, e.speed));
        endtask
    endclass

    logic                        clk           = 1'b0;
    logic                        rst_n         = 1'b0;
    logic                        cfg_wr_en     = 1'b0;
    logic [CFG_INDEX_W-1:0]      cfg_index     = '0;
    logic [CFG_DATA_W-1:0]       cfg_data      = '0;
    logic                        in_valid      = 1'b0;
    logic                        in_stall;
    logic [SW_W-1:0]             switch_pos    = SW_DOWN;
    logic                        fire_button   = 1'b0;
    logic [ANGLE_W-1:0]          encoder_angle = '0;
    logic                        out_valid;
    logic                        out_stall     = 1'b0;
    logic [MODE_W-1:0]           mode;
    logic signed [SPEED_W-1:0]   speed_target;

    feeder_scoreboard    sb = new();
    int                  send_idle   = 16;
    int                  recv_idle   = 77;
    logic [ANGLE_W-1:0]  motor_angle = '0;
    int                  stuck_left  = 0;
    bit                  fire_held   = 1'b0;
    bit                  calm        = 1'b0;

    indexed_feeder_stall_controller dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .switch_pos    (switch_pos),
        .fire_button   (fire_button),
        .encoder_angle (encoder_angle),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .mode          (mode),
        .speed_target  (speed_target)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic send_tick(input logic [SW_W-1:0] sw, input logic fire,
                             input logic [ANGLE_W-1:0] ang);
        if ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle);
        end
        in_valid      <= 1'b1;
        switch_pos    <= sw;
        fire_button   <= fire;
        encoder_angle <= ang;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_request(sw, fire, ang);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (sb.due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic program_regs(input cfg_t c);
        logic [CFG_DATA_W-1:0] vals [NUM_REGS];
        cfg_index_t            idx;
        vals[REG_STEP_COUNTS]      = CFG_DATA_W'(c.step_counts);
        vals[REG_STALL_BAND]       = CFG_DATA_W'(c.stall_band);
        vals[REG_STALL_SHORT]      = CFG_DATA_W'($unsigned(c.stall_short));
        vals[REG_STALL_LONG]       = CFG_DATA_W'($unsigned(c.stall_long));
        vals[REG_REVERSE_TICKS]    = CFG_DATA_W'(c.reverse_ticks);
        vals[REG_ARRIVE_TOLERANCE] = CFG_DATA_W'(c.arrive_tolerance);
        vals[REG_FEED_SPEED]       = CFG_DATA_W'(c.feed_speed);
        vals[REG_FORWARD_DIR]      = CFG_DATA_W'(c.forward_dir);
        idx = idx.first();
        repeat (NUM_REGS)
        begin
            cfg_wr_en <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= vals[idx];
            @(posedge clk);
            idx = idx.next();
        end
        cfg_wr_en <= 1'b0;
        @(posedge clk);
        sb.regs = c;
    endtask

    // step, band, short, long, reverse, tolerance, feed, direction
    function automatic cfg_t phase_regs(int p);
        cfg_t c;
        case (p)
            1: c = '{19'd3000, 13'd200, 16'sd30, 16'sd20, 16'd0,
                     18'd100, 14'd16000, 1'b0};
            2: c = '{19'd524287, 13'd8191, 16'sd32767, 16'sd32767, 16'd65535,
                     18'd147456, 14'd1, 1'b1};
            3: c = '{19'd0, 13'd0, 16'sd990, 16'sd32767, 16'd3,
                     18'd0, 14'd700, 1'b0};
            4: c = '{19'd1, 13'd1000, 16'sh8000, 16'sd32767, 16'd20,
                     18'd2000, 14'd50, 1'b1};
            5: c = '{19'd300000, 13'd300, 16'sd60, 16'sd40, 16'd10,
                     18'd500, 14'd9000, 1'b1};
            default: c = '{19'd36864, 13'd50, 16'sd50, 16'sh8000, 16'd100,
                           18'd500, 14'd0, 1'b1};
        endcase
        return c;
    endfunction

    function automatic int phase_items(int p);
        case (p)
            2:       return 1100;   // long enough for the stall count to hit its ceiling
            3:       return 140;
            4:       return 100;
            6:       return 60;
            default: return 120;
        endcase
    endfunction

    function automatic logic [SW_W-1:0] pick_switch();
        int r;
        r = $urandom_range(999);
        if (r < 20)
            return SW_SPARE;
        if (calm)
            return (r < 50) ? SW_UP : SW_DOWN;
        if (r < 80)
            return SW_UP;
        if (r < 90)
            return SW_MID;
        return SW_DOWN;
    endfunction

    // encoder follows the sign of the last setpoint, with jams and glitches
    function automatic logic [ANGLE_W-1:0] motor_step();
        int mv;
        if (stuck_left > 0)
        begin
            stuck_left--;
            mv = int'($urandom_range(6)) - 3;
        end
        else if ($urandom_range(99) < 2)
        begin
            stuck_left = $urandom_range(140, 20);
            mv = 0;
        end
        else if ($urandom_range(99) < 2)
            mv = int'($urandom_range(ENCODER_RES - 1));
        else if (sb.last_speed > 0)
            mv = int'($urandom_range(700, 1));
        else if (sb.last_speed < 0)
            mv = -int'($urandom_range(700, 1));
        else
            mv = int'($urandom_range(4)) - 2;
        motor_angle = motor_angle + ANGLE_W'(mv);
        return motor_angle;
    endfunction

    task automatic run_random(input int count, input bit pause_midway);
        for (int i = 0; i < count; i++)
        begin
            if (pause_midway && i == count / 2)
                drain_results();
            if ($urandom_range(99) < 4)
                fire_held = !fire_held;
            send_tick(pick_switch(), fire_held, motor_step());
        end
    endtask

    initial
    begin : result_sink
        int seen;
        int hold_left;
        bit held;
        seen      = 0;
        hold_left = 0;
        held      = 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
            begin
                sb.check_result(mode, speed_target);
                seen++;
                if (seen == HOLD_AT && !held)
                begin
                    hold_left = HOLD_CYCLES;
                    held      = 1'b1;
                end
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= ($urandom_range(99) < recv_idle);
        end
    end

    initial
    begin : stimulus
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: switch codes, angle extremes, turn counting both ways
        send_tick(SW_SPARE, 1'b0, 13'd0);
        send_tick(SW_MID,   1'b1, 13'd8191);
        send_tick(SW_UP,    1'b0, 13'd0);
        send_tick(SW_DOWN,  1'b0, 13'd49);
        send_tick(SW_DOWN,  1'b0, 13'd4145);
        send_tick(SW_DOWN,  1'b0, 13'd49);
        send_tick(SW_DOWN,  1'b0, 13'd4145);
        send_tick(SW_DOWN,  1'b0, 13'd3000);
        send_tick(SW_DOWN,  1'b1, 13'd8191);
        send_tick(SW_DOWN,  1'b1, 13'd0);
        send_tick(SW_DOWN,  1'b1, 13'd8191);
        send_tick(SW_MID,   1'b1, 13'd0);
        send_tick(SW_UP,    1'b1, 13'd8191);
        send_tick(SW_SPARE, 1'b1, 13'd8191);
        motor_angle = 13'd8191;

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            if (p > 0)
            begin
                drain_results();
                program_regs(phase_regs(p));
            end
            if (p < 2)
            begin
                send_idle = 16;
                recv_idle = 77;
            end
            else if (p < 4)
            begin
                send_idle = 77;
                recv_idle = 16;
            end
            else
            begin
                send_idle = 0;
                recv_idle = 0;
            end
            calm = (p == 2);
            run_random(phase_items(p), p == 1);
        end

        drain_results();
        if (sb.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin : watchdog
        #3_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule

// ===== indexed_feeder_stall_controller.f =====
rtl/ifsc_pkg.sv
rtl/ifsc_cfg.sv
rtl/ifsc_step.sv
rtl/indexed_feeder_stall_controller.sv
dv/tb_indexed_feeder_stall_controller.sv
